/* design/quadrature_radio_tuner_assert.svh */
// Assertion macros shared by the tuner RTL.
// Both macros sample on the rising edge of clk and are disabled during rst.
`ifndef QUADRATURE_RADIO_TUNER_ASSERT_SVH
`define QUADRATURE_RADIO_TUNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/qrt_pkg.sv */
`default_nettype none

package qrt_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] MHZ_MIN_RESET = 8'd118;
  localparam logic [7:0] MHZ_MAX_RESET = 8'd136;
  localparam logic [7:0] KHZ_MIN_RESET = 8'd0;
  localparam logic [7:0] KHZ_MAX_RESET = 8'd99;

  // Only the first four encoders are wired to a frequency part.
  localparam int TUNED_ENCODERS = 4;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [1:0] {
    REG_MHZ_MIN = 2'd0,
    REG_MHZ_MAX = 2'd1,
    REG_KHZ_MIN = 2'd2,
    REG_KHZ_MAX = 2'd3
  } cfg_reg_t;

  // Layout of the frequency byte store.
  localparam logic [2:0] F_A1_MHZ = 3'd0;
  localparam logic [2:0] F_A1_KHZ = 3'd1;
  localparam logic [2:0] F_A2_MHZ = 3'd2;
  localparam logic [2:0] F_A2_KHZ = 3'd3;
  localparam logic [2:0] F_S1_MHZ = 3'd4;
  localparam logic [2:0] F_S1_KHZ = 3'd5;
  localparam logic [2:0] F_S2_MHZ = 3'd6;
  localparam logic [2:0] F_S2_KHZ = 3'd7;

  typedef logic [7:0] freq_bytes_t [8];

  // Gray-coded pin pair (bit 0 = A, bit 1 = B) to a binary position.
  function automatic logic [1:0] decode_phase(input logic [1:0] pins);
    return {pins[0], pins[0] ^ pins[1]};
  endfunction

  // Adds half of the signed step count to a part and clamps it; the upper
  // bound is tested first, so inverted bounds give the maximum above it, else the minimum.
  function automatic logic [7:0] clamp_part(input logic [7:0] cur, input logic [7:0] cnt,
                                            input logic [7:0] lo, input logic [7:0] hi);
    logic signed [9:0] sum;
    logic [7:0] res;
    sum = $signed({2'b00, cur}) + $signed({{3{cnt[7]}}, cnt[7:1]});
    if (sum > $signed({2'b00, hi})) begin
      res = hi;
    end else if (sum < $signed({2'b00, lo})) begin
      res = lo;
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/qrt_if.sv */
`default_nettype none

interface qrt_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  enc_phases;
  logic [1:0]  swap_req;
  logic        apply_update;
  logic [15:0] load_active1;
  logic [15:0] load_active2;
  logic [15:0] load_standby1;
  logic [15:0] load_standby2;

  modport source (
    output valid, req_type, enc_phases, swap_req, apply_update,
           load_active1, load_active2, load_standby1, load_standby2,
    input  ready
  );
  modport sink (
    input  valid, req_type, enc_phases, swap_req, apply_update,
           load_active1, load_active2, load_standby1, load_standby2,
    output ready
  );
endinterface

interface qrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] active1;
  logic [15:0] standby1;
  logic [15:0] active2;
  logic [15:0] standby2;

  modport source (output valid, active1, standby1, active2, standby2, input ready);
  modport sink (input valid, active1, standby1, active2, standby2, output ready);
endinterface

`default_nettype wire

/* design/quadrature_radio_tuner.sv */
// A result is registered and appears in the cycle after its request transaction.
// The tuner takes one request per cycle while each result is taken when shown.
// The one-deep result register holds a new request back only while a result waits.
// Reset (rst, synchronous, active high) clears the frequencies, step counts and
// swap history, restores the default bounds and marks the phase history unset.
`default_nettype none

`include "quadrature_radio_tuner_assert.svh"

module quadrature_radio_tuner #(
  parameter int NUM_ENCODERS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  qrt_req_if.sink                            req,
  qrt_rsp_if.source                          rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [qrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [qrt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [qrt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);
  import qrt_pkg::*;

  localparam int PHASE_W = (2 * NUM_ENCODERS > 8) ? 2 * NUM_ENCODERS : 8;
  localparam int TUNED = (NUM_ENCODERS < TUNED_ENCODERS) ? NUM_ENCODERS : TUNED_ENCODERS;

  logic [7:0] mhz_min, mhz_max, khz_min, khz_max;

  logic [1:0]  last_phase [NUM_ENCODERS];
  logic [1:0]  last_phase_next [NUM_ENCODERS];
  logic [7:0]  step_delta [NUM_ENCODERS];
  logic [7:0]  step_delta_next [NUM_ENCODERS];
  freq_bytes_t freq, freq_next;
  logic [1:0]  prev_swap, prev_swap_next;
  logic        phase_valid, phase_valid_next;
  logic        rsp_valid;

  logic               req_fire;
  logic               cfg_write;
  logic [PHASE_W-1:0] phases_ext;
  logic [1:0]         rise;
  logic               deltas_small;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Encoders whose pins lie past the input field read as zero phases.
  assign phases_ext = PHASE_W'(req.enc_phases);
  assign rise       = req.swap_req & ~prev_swap;

  always_comb begin
    logic [1:0] now;
    logic [1:0] diff;
    logic [7:0] tmp_mhz;
    logic [7:0] tmp_khz;
    last_phase_next  = last_phase;
    step_delta_next  = step_delta;
    freq_next        = freq;
    prev_swap_next   = prev_swap;
    phase_valid_next = phase_valid;
    now              = '0;
    diff             = '0;
    tmp_mhz          = '0;
    tmp_khz          = '0;
    if (req.req_type == REQ_LOAD) begin
      freq_next[F_A1_MHZ] = req.load_active1[15:8];
      freq_next[F_A1_KHZ] = req.load_active1[7:0];
      freq_next[F_A2_MHZ] = req.load_active2[15:8];
      freq_next[F_A2_KHZ] = req.load_active2[7:0];
      freq_next[F_S1_MHZ] = req.load_standby1[15:8];
      freq_next[F_S1_KHZ] = req.load_standby1[7:0];
      freq_next[F_S2_MHZ] = req.load_standby2[15:8];
      freq_next[F_S2_KHZ] = req.load_standby2[7:0];
    end else begin
      for (int k = 0; k < NUM_ENCODERS; k++) begin
        now  = decode_phase(phases_ext[2*k +: 2]);
        diff = last_phase[k] - now;
        if (!phase_valid) begin
          last_phase_next[k] = now;
        end else if (diff[0]) begin
          // Backward difference of one is a down step, of three an up step.
          last_phase_next[k] = now;
          step_delta_next[k] = step_delta[k] + (diff[1] ? 8'd1 : 8'hFF);
        end
      end
      phase_valid_next = 1'b1;

      if (req.apply_update) begin
        for (int k = 0; k < TUNED; k++) begin
          if (step_delta_next[k] != 8'd0) begin
            freq_next[F_S1_MHZ + 3'(k)] = clamp_part(freq[F_S1_MHZ + 3'(k)],
                step_delta_next[k],
                (k % 2 == 0) ? mhz_min : khz_min,
                (k % 2 == 0) ? mhz_max : khz_max);
          end
        end
        for (int k = 0; k < NUM_ENCODERS; k++) begin
          step_delta_next[k] = {7'd0, step_delta_next[k][0]};
        end
      end

      prev_swap_next = req.swap_req;
      if (rise[0]) begin
        tmp_mhz             = freq_next[F_S1_MHZ];
        tmp_khz             = freq_next[F_S1_KHZ];
        freq_next[F_S1_MHZ] = freq_next[F_A1_MHZ];
        freq_next[F_S1_KHZ] = freq_next[F_A1_KHZ];
        freq_next[F_A1_MHZ] = tmp_mhz;
        freq_next[F_A1_KHZ] = tmp_khz;
      end
      if (rise[1]) begin
        tmp_mhz             = freq_next[F_S2_MHZ];
        tmp_khz             = freq_next[F_S2_KHZ];
        freq_next[F_S2_MHZ] = freq_next[F_A2_MHZ];
        freq_next[F_S2_KHZ] = freq_next[F_A2_KHZ];
        freq_next[F_A2_MHZ] = tmp_mhz;
        freq_next[F_A2_KHZ] = tmp_khz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ENCODERS; k++) begin
        step_delta[k] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        freq[i] <= '0;
      end
      prev_swap   <= '0;
      phase_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (req_fire) begin
        step_delta  <= step_delta_next;
        freq        <= freq_next;
        prev_swap   <= prev_swap_next;
        phase_valid <= phase_valid_next;
        rsp_valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid   <= 1'b0;
      end
    end
  end

  // The phase history is only read once the valid flag is set.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      last_phase <= last_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mhz_min <= MHZ_MIN_RESET;
      mhz_max <= MHZ_MAX_RESET;
      khz_min <= KHZ_MIN_RESET;
      khz_max <= KHZ_MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(paddr[3:2]))
        REG_MHZ_MIN: mhz_min <= pwdata[7:0];
        REG_MHZ_MAX: mhz_max <= pwdata[7:0];
        REG_KHZ_MIN: khz_min <= pwdata[7:0];
        REG_KHZ_MAX: khz_max <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_MHZ_MIN: prdata = CFG_DATA_W'(mhz_min);
      REG_MHZ_MAX: prdata = CFG_DATA_W'(mhz_max);
      REG_KHZ_MIN: prdata = CFG_DATA_W'(khz_min);
      REG_KHZ_MAX: prdata = CFG_DATA_W'(khz_max);
      default:     prdata = '0;
    endcase
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.active1  = {freq[F_A1_MHZ], freq[F_A1_KHZ]};
  assign rsp.standby1 = {freq[F_S1_MHZ], freq[F_S1_KHZ]};
  assign rsp.active2  = {freq[F_A2_MHZ], freq[F_A2_KHZ]};
  assign rsp.standby2 = {freq[F_S2_MHZ], freq[F_S2_KHZ]};

  always_comb begin
    deltas_small = 1'b1;
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      if (step_delta[k][7:1] != 7'd0) begin
        deltas_small = 1'b0;
      end
    end
  end

  `QRT_ASSERT_SAME(a_stall_blocks, rsp.valid && !rsp.ready, !req.ready, "request taken while result stalled")
  `QRT_ASSERT_NEXT(a_fire_shows, req_fire, rsp.valid, "accepted request produced no result")
  `QRT_ASSERT_NEXT(a_apply_clears, req_fire && req.req_type == REQ_TICK && req.apply_update, deltas_small, "step counts not reduced to their odd bit after apply")
  `QRT_ASSERT_NEXT(a_load_active1, req_fire && req.req_type == REQ_LOAD, rsp.active1 == $past(req.load_active1), "host load of radio one active lost")
  `QRT_ASSERT_NEXT(a_idle_holds, !req_fire, $stable({rsp.active1, rsp.standby1, rsp.active2, rsp.standby2}), "frequencies changed without a request")

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  import qrt_pkg::*;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  enc_phases;
    logic [1:0]  swap_req;
    logic        apply_update;
    logic [15:0] load_active1;
    logic [15:0] load_active2;
    logic [15:0] load_standby1;
    logic [15:0] load_standby2;
  } tune_req_t;

  typedef struct packed {
    logic [15:0] active1;
    logic [15:0] standby1;
    logic [15:0] active2;
    logic [15:0] standby2;
  } tune_rsp_t;

  localparam int STALL_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  qrt_req_if req();
  qrt_rsp_if rsp();

  quadrature_radio_tuner dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Predicted tuner state.
  logic [1:0] pos_seen [4];
  logic [7:0] step_cnt [4];
  logic [7:0] freq [8];
  logic [1:0] swap_prev;
  bit         pos_known;
  logic [7:0] mhz_lo, mhz_hi, khz_lo, khz_hi;

  tune_rsp_t expected_freqs [$];
  int errors, items_sent, results_seen, settings_used;

  // Stimulus state: knob positions as binary, current swap request level.
  int         tx_idle_pct, rx_idle_pct;
  int         hold_token, hold_seen, hold_left;
  logic [1:0] knob_pos [4];
  int         knob_dir [4];
  logic [1:0] swap_bits;

  function automatic logic [1:0] pin_pair(input logic [1:0] pos);
    case (pos)
      2'd0: return 2'b00;
      2'd1: return 2'b10;
      2'd2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  function automatic logic [1:0] knob_position(input logic [1:0] pins);
    case (pins)
      2'b00: return 2'd0;
      2'b10: return 2'd1;
      2'b11: return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic tune_rsp_t predict_tuning(input tune_req_t r);
    int         k, j, adj, total;
    logic [1:0] cur, delta, rise;
    logic [7:0] lo, hi, t;
    tune_rsp_t  o;
    if (r.req_type == REQ_LOAD) begin
      {freq[F_A1_MHZ], freq[F_A1_KHZ]} = r.load_active1;
      {freq[F_A2_MHZ], freq[F_A2_KHZ]} = r.load_active2;
      {freq[F_S1_MHZ], freq[F_S1_KHZ]} = r.load_standby1;
      {freq[F_S2_MHZ], freq[F_S2_KHZ]} = r.load_standby2;
    end else begin
      for (k = 0; k < 4; k++) begin
        cur = knob_position(r.enc_phases[2*k +: 2]);
        if (!pos_known) begin
          pos_seen[k] = cur;
        end else begin
          delta = pos_seen[k] - cur;
          // An odd difference is a single detent; a jump of two is ignored.
          if (delta[0]) begin
            pos_seen[k] = cur;
            step_cnt[k] = step_cnt[k] + (delta[1] ? 8'd1 : 8'hFF);
          end
        end
      end
      pos_known = 1'b1;
      if (r.apply_update) begin
        for (k = 0; k < 4; k++) begin
          adj = int'($signed(step_cnt[k]));
          adj = adj >>> 1;
          if (step_cnt[k] != 8'd0) begin
            lo = (k % 2 == 1) ? khz_lo : mhz_lo;
            hi = (k % 2 == 1) ? khz_hi : mhz_hi;
            total = int'(freq[F_S1_MHZ + k]) + adj;
            if (total > int'(hi)) begin
              freq[F_S1_MHZ + k] = hi;
            end else if (total < int'(lo)) begin
              freq[F_S1_MHZ + k] = lo;
            end else begin
              freq[F_S1_MHZ + k] = total[7:0];
            end
          end
          step_cnt[k] = {7'd0, step_cnt[k][0]};
        end
      end
      rise = r.swap_req & ~swap_prev;
      swap_prev = r.swap_req;
      // Radio k keeps its active pair at 2k and its standby pair at 4 + 2k.
      for (k = 0; k < 2; k++) begin
        if (rise[k]) begin
          for (j = 0; j < 2; j++) begin
            t = freq[2*k + j];
            freq[2*k + j] = freq[4 + 2*k + j];
            freq[4 + 2*k + j] = t;
          end
        end
      end
    end
    o.active1  = {freq[F_A1_MHZ], freq[F_A1_KHZ]};
    o.standby1 = {freq[F_S1_MHZ], freq[F_S1_KHZ]};
    o.active2  = {freq[F_A2_MHZ], freq[F_A2_KHZ]};
    o.standby2 = {freq[F_S2_MHZ], freq[F_S2_KHZ]};
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    tune_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_freqs.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending: expected none, actual %h %h %h %h",
                 $time, rsp.active1, rsp.standby1, rsp.active2, rsp.standby2);
      end else begin
        want = expected_freqs.pop_front();
        check_field("active1", want.active1, rsp.active1);
        check_field("standby1", want.standby1, rsp.standby1);
        check_field("active2", want.active2, rsp.active2);
        check_field("standby2", want.standby2, rsp.standby2);
        results_seen++;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever hold_token moves.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= STALL_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every task below starts and returns just after a rising edge.
  task automatic send_req(input tune_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.req_type      <= r.req_type;
    req.enc_phases    <= r.enc_phases;
    req.swap_req      <= r.swap_req;
    req.apply_update  <= r.apply_update;
    req.load_active1  <= r.load_active1;
    req.load_active2  <= r.load_active2;
    req.load_standby1 <= r.load_standby1;
    req.load_standby2 <= r.load_standby2;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_freqs.push_back(predict_tuning(r));
    items_sent++;
  endtask

  task automatic pause_until_drained();
    req.valid <= 1'b0;
    while (expected_freqs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MHZ_MIN: mhz_lo = val;
      REG_MHZ_MAX: mhz_hi = val;
      REG_KHZ_MIN: khz_lo = val;
      REG_KHZ_MAX: khz_hi = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_bounds(input logic [7:0] m_lo, input logic [7:0] m_hi,
                            input logic [7:0] k_lo, input logic [7:0] k_hi);
    write_reg(REG_MHZ_MIN, m_lo);
    write_reg(REG_MHZ_MAX, m_hi);
    write_reg(REG_KHZ_MIN, k_lo);
    write_reg(REG_KHZ_MAX, k_hi);
    settings_used++;
  endtask

  task automatic tick(input logic [1:0] swap, input logic apply);
    tune_req_t r;
    int        k;
    r.req_type = REQ_TICK;
    for (k = 0; k < 4; k++) r.enc_phases[2*k +: 2] = pin_pair(knob_pos[k]);
    r.swap_req      = swap;
    r.apply_update  = apply;
    r.load_active1  = 16'($urandom);
    r.load_active2  = 16'($urandom);
    r.load_standby1 = 16'($urandom);
    r.load_standby2 = 16'($urandom);
    send_req(r);
  endtask

  // The knob, swap and apply fields of a load carry noise that must be ignored.
  task automatic host_load(input logic [15:0] a1, input logic [15:0] a2,
                           input logic [15:0] s1, input logic [15:0] s2);
    tune_req_t r;
    r.req_type      = REQ_LOAD;
    r.enc_phases    = 8'($urandom);
    r.swap_req      = 2'($urandom);
    r.apply_update  = 1'($urandom);
    r.load_active1  = a1;
    r.load_active2  = a2;
    r.load_standby1 = s1;
    r.load_standby2 = s2;
    send_req(r);
  endtask

  task automatic turn(input int k, input int dir);
    knob_pos[k] = knob_pos[k] + 2'(dir);
  endtask

  task automatic spin(input int k, input int dir, input int n);
    repeat (n) begin
      turn(k, dir);
      tick(swap_bits, 1'b0);
    end
  endtask

  function automatic logic [15:0] rand_freq();
    if ($urandom_range(1) == 1) return 16'($urandom);
    return {8'($urandom_range(mhz_hi, mhz_lo)), 8'($urandom_range(khz_hi, khz_lo))};
  endfunction

  // Mostly plausible knob motion with a bias per knob; now and then a skipped
  // detent, a scrambled pin set or a host load.
  task automatic random_step();
    int k, p;
    if ($urandom_range(99) < 4) begin
      host_load(rand_freq(), rand_freq(), rand_freq(), rand_freq());
    end else begin
      for (k = 0; k < 4; k++) begin
        if ($urandom_range(99) < 5) knob_dir[k] = -knob_dir[k];
        p = $urandom_range(99);
        if (p < 40) begin
          turn(k, knob_dir[k]);
        end else if (p < 48) begin
          turn(k, -knob_dir[k]);
        end else if (p < 51) begin
          turn(k, 2);
        end
      end
      if ($urandom_range(99) < 3) begin
        for (k = 0; k < 4; k++) knob_pos[k] = 2'($urandom);
      end
      for (k = 0; k < 2; k++) begin
        if ($urandom_range(99) < 12) swap_bits[k] = ~swap_bits[k];
      end
      tick(swap_bits, $urandom_range(99) < 10);
    end
  endtask

  task automatic test_first_tick();
    knob_pos = '{2'd0, 2'd1, 2'd2, 2'd3};
    tick(2'b00, 1'b1);
    turn(0, 1);
    turn(1, -1);
    turn(2, 1);
    turn(3, -1);
    tick(2'b00, 1'b0);
  endtask

  task automatic test_host_load();
    host_load(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    host_load(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    host_load(16'h7663, 16'h8001, 16'h7600, 16'h8863);
  endtask

  task automatic test_knob_steps();
    swap_bits = 2'b00;
    // A count of one shifts by zero but still pulls the part into bounds.
    tick(2'b00, 1'b1);
    turn(0, 1);
    tick(2'b00, 1'b1);
    spin(0, 1, 3);
    spin(1, -1, 3);
    spin(2, 1, 3);
    tick(2'b00, 1'b1);
    turn(3, 2);
    tick(2'b00, 1'b0);
    turn(3, 1);
    tick(2'b00, 1'b1);
  endtask

  task automatic test_swaps();
    tick(2'b01, 1'b0);
    tick(2'b01, 1'b0);
    tick(2'b11, 1'b0);
    host_load(16'h7A10, 16'h8222, 16'h7B33, 16'h8444);
    tick(2'b11, 1'b0);
    tick(2'b00, 1'b0);
    tick(2'b11, 1'b1);
    tick(2'b10, 1'b0);
    swap_bits = 2'b10;
  endtask

  task automatic test_count_wrap();
    pause_until_drained();
    set_bounds(8'd0, 8'd255, 8'd0, 8'd255);
    host_load(16'h0000, 16'h0000, 16'hF00F, 16'hFF00);
    spin(0, 1, 130);
    spin(1, -1, 131);
    spin(2, 1, 4);
    spin(3, -1, 4);
    tick(swap_bits, 1'b1);
  endtask

  task automatic test_backpressure();
    pause_until_drained();
    tx_idle_pct = 0;
    hold_token <= hold_token + 1;
    repeat (40) random_step();
    pause_until_drained();
    tx_idle_pct = 35;
  endtask

  task automatic test_random_bounds();
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      pause_until_drained();
      case (ph)
        0: set_bounds(MHZ_MIN_RESET, MHZ_MAX_RESET, KHZ_MIN_RESET, KHZ_MAX_RESET);
        1: set_bounds(8'd0, 8'd255, 8'd0, 8'd255);
        2: set_bounds(8'd255, 8'd0, 8'd255, 8'd0);
        3: set_bounds(8'd100, 8'd100, 8'd50, 8'd50);
        default: set_bounds(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // One phase runs with no idling on either side.
      tx_idle_pct = (ph == 1) ? 0 : 35;
      rx_idle_pct <= (ph == 1) ? 0 : 35;
      repeat (110) random_step();
    end
  endtask

  initial begin
    req.valid         = 1'b0;
    req.req_type      = REQ_TICK;
    req.enc_phases    = 8'd0;
    req.swap_req      = 2'b00;
    req.apply_update  = 1'b0;
    req.load_active1  = 16'd0;
    req.load_active2  = 16'd0;
    req.load_standby1 = 16'd0;
    req.load_standby2 = 16'd0;
    rsp.ready         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mhz_lo            = MHZ_MIN_RESET;
    mhz_hi            = MHZ_MAX_RESET;
    khz_lo            = KHZ_MIN_RESET;
    khz_hi            = KHZ_MAX_RESET;
    pos_seen          = '{default: 2'd0};
    step_cnt          = '{default: 8'd0};
    freq              = '{default: 8'd0};
    swap_prev         = 2'b00;
    pos_known         = 1'b0;
    knob_pos          = '{default: 2'd0};
    knob_dir          = '{default: 1};
    swap_bits         = 2'b00;
    tx_idle_pct       = 35;
    rx_idle_pct       = 35;
    hold_token        = 0;
    hold_seen         = 0;
    hold_left         = 0;
    errors            = 0;
    items_sent        = 0;
    results_seen      = 0;
    settings_used     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_first_tick();
    test_host_load();
    test_knob_steps();
    test_swaps();
    test_count_wrap();
    test_backpressure();
    test_random_bounds();
    pause_until_drained();

    $display("Sent %0d transactions and checked %0d results under %0d bound settings.",
             items_sent, results_seen, settings_used);
    $display("Covered host loads, swap edges, step count wrap, clamping and a long output stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still pending.", expected_freqs.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
